// ===== rtl/hte_pkg.sv =====
// Package for the HTML text escaper: word types, register indexes and character codes.
// Also holds the expansion function that turns one text byte into its escaped spelling.
// Depends on nothing; every other file of the block imports it.
package hte_pkg;

  localparam int JOB_MAX     = 6;
  localparam int LEN_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NL_BR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       text_end;
  } out_word_t;

  typedef struct packed {
    logic [JOB_MAX-1:0][7:0] chars;
    logic [LEN_W-1:0]        len;
    logic                    fin;
  } job_t;

  function automatic job_t hte_expand(input logic [7:0] b, input logic fin,
                                      input logic nl_br, input logic mask);
    job_t        j;
    logic [1:0]  h;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [3:0]  t;
    logic [3:0]  o;
    j       = '0;
    j.fin   = fin;
    j.len   = 3'd1;
    h       = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    rem     = b - 8'(h) * 8'd100;
    prod    = 16'(rem) * 16'd205;
    t       = 4'(prod >> 11);
    o       = 4'(rem - 8'(t) * 8'd10);
    case (b)
      CH_LT: begin
        j.chars[0] = CH_AMP; j.chars[1] = "l"; j.chars[2] = "t"; j.chars[3] = ";";
        j.len = 3'd4;
      end
      CH_GT: begin
        j.chars[0] = CH_AMP; j.chars[1] = "g"; j.chars[2] = "t"; j.chars[3] = ";";
        j.len = 3'd4;
      end
      CH_AMP: begin
        j.chars[0] = CH_AMP; j.chars[1] = "a"; j.chars[2] = "m"; j.chars[3] = "p";
        j.chars[4] = ";";
        j.len = 3'd5;
      end
      CH_QUOT: begin
        j.chars[0] = CH_AMP; j.chars[1] = "q"; j.chars[2] = "u"; j.chars[3] = "o";
        j.chars[4] = "t"; j.chars[5] = ";";
        j.len = 3'd6;
      end
      CH_LF: begin
        j.chars[0] = CH_LF;
        if (nl_br) begin
          j.chars[1] = CH_LT; j.chars[2] = "b"; j.chars[3] = "r"; j.chars[4] = CH_GT;
          j.len = 3'd5;
        end
      end
      default: begin
        if ((b >= CH_SPACE && !b[7]) || b == CH_CR || b == CH_TAB) begin
          j.chars[0] = b;
        end else begin
          j.chars[0] = CH_AMP;
          j.chars[1] = "#";
          if (h != 2'd0) begin
            j.chars[2] = CH_ZERO + 8'(h);
            j.chars[3] = CH_ZERO + 8'(t);
            j.chars[4] = CH_ZERO + 8'(o);
            j.chars[5] = ";";
            j.len = 3'd6;
          end else if (t != 4'd0) begin
            j.chars[2] = CH_ZERO + 8'(t);
            j.chars[3] = CH_ZERO + 8'(o);
            j.chars[4] = ";";
            j.len = 3'd5;
          end else begin
            j.chars[2] = CH_ZERO + 8'(o);
            j.chars[3] = ";";
            j.len = 3'd4;
          end
        end
      end
    endcase
    for (int k = 0; k < JOB_MAX; k++) begin
      if (mask && (j.chars[k] < CH_SPACE || j.chars[k] > CH_TILDE)) begin
        j.chars[k] = CH_QMARK;
      end
    end
    return j;
  endfunction

endpackage

// ===== rtl/html_text_escaper.sv =====
// HTML text escaper, top level. The first character of an accepted word passes through the job
// queue and then the output register. Throughput: one output character per cycle while out_stall
// is low, set by the single output port, so a copied byte yields one character and an expanded
// byte up to six. Reset is synchronous and active low; it clears both configuration bits, the job
// queue and the output valid. Depends on hte_pkg, hte_front, hte_queue and hte_back.
module html_text_escaper #(
  parameter int QUEUE_DEPTH = hte_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hte_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hte_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hte_pkg::out_word_t             out_word
);
  import hte_pkg::*;

  logic push;
  logic pop;
  logic q_valid;
  logic q_full;
  job_t push_job;
  job_t head_job;

  hte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_job  (push_job)
  );

  hte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head_job (head_job)
  );

  hte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.text_end |-> out_word.last_of_run)
    else $error("text end flagged on a word that does not close its run");

  a_accept_queues: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> q_valid)
    else $error("accepted word did not reach the job queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== rtl/hte_front.sv =====
// Front end of the HTML text escaper: configuration registers and byte classification.
// Turns each accepted word into a job of up to six characters. Depends on hte_pkg.
module hte_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hte_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [hte_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  input  hte_pkg::in_word_t                  in_word,
  input  logic                               q_full,
  output logic                               in_stall,
  output logic                               push,
  output hte_pkg::job_t                      push_job
);
  import hte_pkg::*;

  logic nl_br_r;
  logic nl_br_nxt;
  logic mask_r;
  logic mask_nxt;

  always_comb begin
    nl_br_nxt = nl_br_r;
    mask_nxt  = mask_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_NL_BR: nl_br_nxt = cfg_wdata[0];
        CFG_MASK:  mask_nxt  = cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_br_r <= 1'b0;
      mask_r  <= 1'b0;
    end else begin
      nl_br_r <= nl_br_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign push_job = hte_expand(in_word.in_byte, in_word.final_byte, nl_br_r, mask_r);

endmodule

// ===== rtl/hte_queue.sv =====
// Short job queue of the HTML text escaper, between the classifier and the serialiser.
// Register-based FIFO of job_t entries. Depends on hte_pkg.
module hte_queue #(
  parameter int DEPTH = hte_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hte_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output hte_pkg::job_t head_job
);
  import hte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_pop;

  assign do_pop   = pop && (count_r != '0);
  assign q_valid  = (count_r != '0);
  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/hte_back.sv =====
// Back end of the HTML text escaper: steps through the head job one character a cycle
// while not stalled. Holds the output register and the character index. Depends on hte_pkg.
module hte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hte_pkg::job_t      head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output hte_pkg::out_word_t out_word
);
  import hte_pkg::*;

  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] idx_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;
  logic             load;
  logic             last;

  assign load = q_valid && (!out_valid_r || !out_stall);
  assign last = (idx_r == head_job.len - 3'd1);
  assign pop  = load && last;

  always_comb begin
    idx_nxt                  = idx_r;
    out_valid_nxt            = out_valid_r && out_stall;
    out_word_nxt             = out_word_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.out_char    = head_job.chars[idx_r];
      out_word_nxt.last_of_run = last;
      out_word_nxt.text_end    = last && head_job.fin;
      idx_nxt                  = last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sim/html_text_escaper_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for html_text_escaper: drives text bytes with bursty valid and a
// patterned output stall, predicts each escaped character and compares every output word.
// Depends on hte_pkg for the word types, register indexes and character codes.
module html_text_escaper_tb;
  import hte_pkg::*;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic       nl_br;
    logic       mask;
    logic [7:0] text_byte;
    logic       fin;
    string      spelled;
  } text_row_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int NUM_ROWS = 25;
  localparam int RANDOM_BYTES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_NL_BR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  logic nl_br_now = 1'b0;
  logic mask_now = 1'b0;
  out_word_t expected_chars[$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  // An empty spelling means the row is checked against the predictor.
  text_row_t text_rows[NUM_ROWS] = '{
    '{1'b0, 1'b0, CH_LT,    1'b0, "&lt;"},
    '{1'b0, 1'b0, CH_GT,    1'b0, "&gt;"},
    '{1'b0, 1'b0, CH_AMP,   1'b0, "&amp;"},
    '{1'b0, 1'b0, CH_QUOT,  1'b0, "&quot;"},
    '{1'b0, 1'b0, CH_LF,    1'b0, "\n"},
    '{1'b0, 1'b0, 8'h00,    1'b0, "&#0;"},
    '{1'b0, 1'b0, 8'hFF,    1'b1, "&#255;"},
    '{1'b0, 1'b0, CH_TAB,   1'b0, "\t"},
    '{1'b0, 1'b0, CH_CR,    1'b0, ""},
    '{1'b0, 1'b0, 8'h7F,    1'b0, ""},
    '{1'b0, 1'b0, CH_SPACE, 1'b0, " "},
    '{1'b0, 1'b0, CH_TILDE, 1'b0, "~"},
    '{1'b0, 1'b0, 8'h80,    1'b0, "&#128;"},
    '{1'b0, 1'b0, 8'h1F,    1'b1, "&#31;"},
    '{1'b0, 1'b0, 8'h64,    1'b0, ""},
    '{1'b1, 1'b0, CH_LF,    1'b0, "\n<br>"},
    '{1'b1, 1'b0, 8'h41,    1'b1, "A"},
    '{1'b1, 1'b1, CH_LF,    1'b0, "?<br>"},
    '{1'b1, 1'b1, CH_TAB,   1'b0, "?"},
    '{1'b1, 1'b1, CH_CR,    1'b0, "?"},
    '{1'b1, 1'b1, 8'h7F,    1'b0, "?"},
    '{1'b1, 1'b1, 8'h05,    1'b0, "&#5;"},
    '{1'b1, 1'b1, 8'hC8,    1'b1, "&#200;"},
    '{1'b0, 1'b1, CH_LF,    1'b1, "?"},
    '{1'b0, 1'b1, 8'h9F,    1'b0, ""}
  };

  html_text_escaper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic char_q_t text_to_chars(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  function automatic void queue_run(char_q_t spell, logic fin);
    out_word_t w;
    for (int k = 0; k < spell.size(); k++) begin
      w.out_char    = spell[k];
      w.last_of_run = (k == spell.size() - 1);
      w.text_end    = w.last_of_run && fin;
      expected_chars.push_back(w);
    end
  endfunction

  function automatic void escape_byte(in_word_t w);
    char_q_t spell;
    logic [7:0] b;
    b = w.in_byte;
    case (b)
      CH_LT:   spell = text_to_chars("&lt;");
      CH_GT:   spell = text_to_chars("&gt;");
      CH_AMP:  spell = text_to_chars("&amp;");
      CH_QUOT: spell = text_to_chars("&quot;");
      CH_LF: begin
        spell.push_back(CH_LF);
        if (nl_br_now) spell = {spell, text_to_chars("<br>")};
      end
      default: begin
        if ((b >= CH_SPACE && !b[7]) || b == CH_CR || b == CH_TAB) begin
          spell.push_back(b);
        end else begin
          spell = text_to_chars("&#");
          if (b >= 100) spell.push_back(8'(CH_ZERO + b / 100));
          if (b >= 10) spell.push_back(8'(CH_ZERO + (b / 10) % 10));
          spell.push_back(8'(CH_ZERO + b % 10));
          spell.push_back(";");
        end
      end
    endcase
    for (int k = 0; k < spell.size(); k++) begin
      if (mask_now && (spell[k] < CH_SPACE || spell[k] > CH_TILDE)) spell[k] = CH_QMARK;
    end
    queue_run(spell, w.final_byte);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    logic [7:0] specials[7];
    specials = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_LF, CH_TAB, CH_CR};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w.in_byte = specials[$urandom_range(0, 6)];
      4, 5, 6:    w.in_byte = 8'($urandom_range(32, 127));
      default:    w.in_byte = 8'($urandom);
    endcase
    w.final_byte = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  // Bursts of random length, each preceded by a random gap that is often zero.
  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (expected_chars.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  // The spare indexes are written too; the block must ignore them.
  task automatic write_regs(logic nl_br, logic mask);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NL_BR;
    cfg_wdata <= nl_br;
    @(negedge clk);
    cfg_idx   <= CFG_MASK;
    cfg_wdata <= mask;
    @(negedge clk);
    cfg_idx   <= CFG_SPARE_LO;
    cfg_wdata <= 1'($urandom);
    @(negedge clk);
    cfg_idx   <= CFG_SPARE_HI;
    cfg_wdata <= 1'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b0;
    nl_br_now = nl_br;
    mask_now  = mask;
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 50 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5 < 3);
    endcase
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_word);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_word.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h got %h", $time, want.out_char, out_word.out_char);
          errors++;
        end
        if (out_word.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last_of_run,
                   out_word.last_of_run);
          errors++;
        end
        if (out_word.text_end !== want.text_end) begin
          $display("%0t: text_end expected %b got %b", $time, want.text_end, out_word.text_end);
          errors++;
        end
      end
    end
  end

  initial begin
    in_word_t w;
    logic nl_br;
    logic mask;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first rows run on the register values left by reset.
    foreach (text_rows[r]) begin
      if (text_rows[r].nl_br != nl_br_now || text_rows[r].mask != mask_now) begin
        drain();
        write_regs(text_rows[r].nl_br, text_rows[r].mask);
      end
      w.in_byte    = text_rows[r].text_byte;
      w.final_byte = text_rows[r].fin;
      send_word(w);
      if (text_rows[r].spelled.len() == 0) escape_byte(w);
      else queue_run(text_to_chars(text_rows[r].spelled), w.final_byte);
    end

    for (int p = 0; p < 5; p++) begin
      nl_br = (p < 4) ? p[0] : 1'($urandom);
      mask  = (p < 4) ? p[1] : 1'($urandom);
      drain();
      write_regs(nl_br, mask);
      for (int i = 0; i < RANDOM_BYTES / 5; i++) begin
        w = random_word();
        send_word(w);
        escape_byte(w);
      end
    end
    drain();

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("html_text_escaper regression: pass");
    end else begin
      $display("html_text_escaper regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("html_text_escaper regression: fail");
    $finish;
  end

endmodule
